@@ design/prot_pkg.sv @@
// Shared types, constants and tables of the point rotation block.
`default_nettype none
package prot_pkg;

	// Field widths
	localparam int COORD_W = 24;
	localparam int ANGLE_W = 16;
	localparam int EXT_W   = COORD_W + 1;

	// Angle units: 1/64 degree
	localparam int TURN_UNITS    = 23040;
	localparam int QUARTER_UNITS = 5760;
	localparam int EIGHTH_UNITS  = 2880;

	// Residual angle to binary angle: z = q * 2^23 + frac(rem), with mag = 45 * q + rem
	localparam int MAG_W       = 12;
	localparam int QUO_W       = 7;
	localparam int REM_W       = 6;
	localparam int FRAC_W      = 23;
	localparam int ZMAG_W      = QUO_W + FRAC_W;
	localparam int Z_DIV       = 45;
	localparam int Z_BIAS      = 22;
	localparam int RECIP_DIV   = 2913;
	localparam int RECIP_SHIFT = 17;
	localparam int RECIP_W     = MAG_W + 12;

	// Rotation datapath
	localparam int GUARD_BITS = 8;
	localparam int CORDIC_W   = 35;
	localparam int Z_W        = 32;
	localparam int ATAN_LEN   = 30;

	// Gain correction
	localparam int GAIN_W      = 24;
	localparam logic [GAIN_W-1:0] GAIN_Q24 = 24'd10188014;
	localparam int GAIN_SPLIT  = 17;
	localparam int ROUND_BIT   = 31;
	localparam int GAIN_SHIFT  = 32;
	localparam int COORD_MAX   = 8388607;
	localparam int COORD_MIN   = -8388608;

	// Defaults
	localparam int ROTATION_STEPS_DEF = 16;
	localparam int MID_DEPTH          = 4;
	localparam int OUT_DEPTH          = 2;

	// Queue status
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Item handed from the front to the rotation pipeline
	typedef struct packed {
		logic signed [EXT_W-1:0] ax;
		logic signed [EXT_W-1:0] ay;
		logic signed [Z_W-1:0]   z;
	} mid_entry_t;

	// Finished result item
	typedef struct packed {
		logic signed [COORD_W-1:0] rx;
		logic signed [COORD_W-1:0] ry;
	} out_entry_t;

	// atan(2^-i) in binary angle units, truncated
	localparam logic [Z_W-1:0] ATAN_TAB [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
	};

	// Fraction part of the angle conversion, one entry per remainder
	localparam int FRAC_LEN = 2 ** REM_W;
	typedef logic [FRAC_W-1:0] frac_tab_t [FRAC_LEN];

	function automatic frac_tab_t build_frac_tab();
		frac_tab_t t;
		for (int b = 0; b < FRAC_LEN; b++) begin
			t[b] = FRAC_W'(((longint'(b) << FRAC_W) + Z_BIAS) / Z_DIV);
		end
		return t;
	endfunction

	localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage
`default_nettype wire

@@ design/prot_fifo.sv @@
// Small flop-based queue used between pipeline parts and at the result side.
`default_nettype none
module prot_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output prot_pkg::fifo_stat_t  stat
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;

	// Store the incoming item
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CNTW'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("item pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("item popped from an empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(DEPTH))
		else $error("queue occupancy beyond depth");

endmodule
`default_nettype wire

@@ design/prot_front.sv @@
// Front part: accepts items, reduces the angle to a quadrant and a residual binary angle.
`default_nettype none
module prot_front (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  push,
	input  wire logic signed [prot_pkg::COORD_W-1:0]   point_x,
	input  wire logic signed [prot_pkg::COORD_W-1:0]   point_y,
	input  wire logic signed [prot_pkg::ANGLE_W-1:0]   angle,
	output logic                                       full,
	input  wire prot_pkg::fifo_stat_t                  q_stat,
	output logic                                       q_push,
	output prot_pkg::mid_entry_t                       q_data
);

	localparam int EW = prot_pkg::EXT_W;
	localparam int AW = 18;

	typedef enum logic [1:0] {
		QUAD_0   = 2'd0,
		QUAD_90  = 2'd1,
		QUAD_180 = 2'd2,
		QUAD_270 = 2'd3
	} quad_t;

	localparam logic signed [AW-1:0] TURN_S  = AW'(prot_pkg::TURN_UNITS);
	localparam logic signed [AW-1:0] TURN2_S = AW'(2 * prot_pkg::TURN_UNITS);
	localparam logic signed [AW-1:0] QTR_S   = AW'(prot_pkg::QUARTER_UNITS);
	localparam logic signed [AW-1:0] B1_S    = AW'(prot_pkg::EIGHTH_UNITS);
	localparam logic signed [AW-1:0] B2_S    =
		AW'(prot_pkg::EIGHTH_UNITS + prot_pkg::QUARTER_UNITS);
	localparam logic signed [AW-1:0] B3_S    =
		AW'(prot_pkg::EIGHTH_UNITS + 2 * prot_pkg::QUARTER_UNITS);
	localparam logic signed [AW-1:0] B4_S    =
		AW'(prot_pkg::EIGHTH_UNITS + 3 * prot_pkg::QUARTER_UNITS);

	logic adv;
	logic vld_s1, vld_s2, vld_s3;

	logic signed [AW-1:0] ang_w, m_w, r_w;
	logic signed [EW-1:0] px_w, py_w, ax_w, ay_w;
	logic [prot_pkg::MAG_W-1:0] mag_w;
	quad_t quad_w;

	logic signed [EW-1:0] ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3;
	logic [prot_pkg::MAG_W-1:0] mag_s1, mag_s2;
	logic neg_s1, neg_s2;
	logic [prot_pkg::QUO_W-1:0] quo_s2;
	logic signed [prot_pkg::Z_W-1:0] z_s3;

	logic [prot_pkg::RECIP_W-1:0] prod_w;
	logic [prot_pkg::MAG_W-1:0]   rem_full_w;
	logic [prot_pkg::REM_W-1:0]   rem_w;
	logic [prot_pkg::ZMAG_W-1:0]  zmag_w;
	logic signed [prot_pkg::Z_W-1:0] z_w;

	// The whole front moves together; it halts only when its last stage cannot drain
	assign adv    = !vld_s3 || !q_stat.full;
	assign full   = !adv;
	assign q_push = vld_s3 && adv;

	// Wrap the angle to one turn and pick the nearest quarter turn
	always_comb begin
		ang_w = AW'(angle);
		if (ang_w < -TURN_S) begin
			m_w = ang_w + TURN2_S;
		end else if (ang_w < 0) begin
			m_w = ang_w + TURN_S;
		end else if (ang_w >= TURN_S) begin
			m_w = ang_w - TURN_S;
		end else begin
			m_w = ang_w;
		end
		if (m_w < B1_S) begin
			quad_w = QUAD_0;
			r_w    = m_w;
		end else if (m_w < B2_S) begin
			quad_w = QUAD_90;
			r_w    = m_w - QTR_S;
		end else if (m_w < B3_S) begin
			quad_w = QUAD_180;
			r_w    = m_w - (QTR_S <<< 1);
		end else if (m_w < B4_S) begin
			quad_w = QUAD_270;
			r_w    = m_w - TURN_S + QTR_S;
		end else begin
			quad_w = QUAD_0;
			r_w    = m_w - TURN_S;
		end
		mag_w = r_w[AW-1] ? prot_pkg::MAG_W'(-r_w) : prot_pkg::MAG_W'(r_w);
	end

	// Apply the quarter turn exactly by swap and negate
	always_comb begin
		px_w = EW'(point_x);
		py_w = EW'(point_y);
		case (quad_w)
			QUAD_90: begin
				ax_w = -py_w;
				ay_w = px_w;
			end
			QUAD_180: begin
				ax_w = -px_w;
				ay_w = -py_w;
			end
			QUAD_270: begin
				ax_w = py_w;
				ay_w = -px_w;
			end
			default: begin
				ax_w = px_w;
				ay_w = py_w;
			end
		endcase
	end

	// Quotient of the magnitude by 45 through a reciprocal
	assign prod_w = prot_pkg::RECIP_W'(mag_s1) * prot_pkg::RECIP_W'(prot_pkg::RECIP_DIV);

	// Remainder, fraction lookup and sign of the binary angle
	always_comb begin
		rem_full_w = mag_s2 - prot_pkg::MAG_W'(quo_s2) * prot_pkg::MAG_W'(prot_pkg::Z_DIV);
		rem_w      = rem_full_w[prot_pkg::REM_W-1:0];
		zmag_w     = {quo_s2, {prot_pkg::FRAC_W{1'b0}}}
			+ prot_pkg::ZMAG_W'(prot_pkg::FRAC_TAB[rem_w]);
		z_w        = neg_s2 ? -prot_pkg::Z_W'(zmag_w) : prot_pkg::Z_W'(zmag_w);
	end

	// Hold stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= push;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Advance stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1  <= ax_w;
			ay_s1  <= ay_w;
			mag_s1 <= mag_w;
			neg_s1 <= r_w[AW-1];
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			quo_s2 <= prod_w[prot_pkg::RECIP_SHIFT +: prot_pkg::QUO_W];
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			z_s3   <= z_w;
		end
	end

	assign q_data.ax = ax_s3;
	assign q_data.ay = ay_s3;
	assign q_data.z  = z_s3;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && q_stat.full |=> vld_s3 && $stable(z_s3) && $stable(ax_s3))
		else $error("front item changed while the queue was full");

endmodule
`default_nettype wire

@@ design/prot_back.sv @@
// Back part: pipelined CORDIC rotation, gain correction and saturation.
`default_nettype none
module prot_back #(
	parameter int ROTATION_STEPS = prot_pkg::ROTATION_STEPS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire prot_pkg::mid_entry_t q_head,
	input  wire prot_pkg::fifo_stat_t q_stat,
	output logic                      q_pop,
	input  wire prot_pkg::fifo_stat_t o_stat,
	output logic                      o_push,
	output prot_pkg::out_entry_t      o_data
);

	localparam int STEPS = (ROTATION_STEPS > prot_pkg::ATAN_LEN) ?
		prot_pkg::ATAN_LEN : ROTATION_STEPS;
	localparam int LAST  = STEPS + 2;
	localparam int CW    = prot_pkg::CORDIC_W;
	localparam int ZW    = prot_pkg::Z_W;
	localparam int SPLIT = prot_pkg::GAIN_SPLIT;
	localparam int HI_W  = CW - SPLIT;
	localparam int PH_W  = HI_W + prot_pkg::GAIN_W + 1;
	localparam int PL_W  = SPLIT + prot_pkg::GAIN_W;
	localparam int SW    = CW + prot_pkg::GAIN_W + 1;
	localparam int RW    = SW - prot_pkg::GAIN_SHIFT;
	localparam int OW    = prot_pkg::COORD_W;

	localparam logic signed [SW-1:0] ROUND_C = SW'(64'd1 << prot_pkg::ROUND_BIT);
	localparam logic signed [RW-1:0] CMAX    = RW'(prot_pkg::COORD_MAX);
	localparam logic signed [RW-1:0] CMIN    = RW'(prot_pkg::COORD_MIN);
	localparam logic signed [PH_W-1:0] GAIN_S = PH_W'(prot_pkg::GAIN_Q24);

	logic adv;
	logic vld_s [LAST+1];

	logic signed [CW-1:0] rx_s [STEPS+1];
	logic signed [CW-1:0] ry_s [STEPS+1];
	logic signed [ZW-1:0] rz_s [STEPS];

	logic signed [PH_W-1:0] phx_s1, phy_s1;
	logic [PL_W-1:0]        plx_s1, ply_s1;
	logic signed [OW-1:0]   resx_s2, resy_s2;

	logic signed [SW-1:0] sumx_w, sumy_w;

	// Clip a corrected value to the coordinate range
	function automatic logic signed [OW-1:0] sat(input logic signed [RW-1:0] v);
		logic signed [OW-1:0] r;
		if (v > CMAX) begin
			r = OW'(prot_pkg::COORD_MAX);
		end else if (v < CMIN) begin
			r = OW'(prot_pkg::COORD_MIN);
		end else begin
			r = v[OW-1:0];
		end
		return r;
	endfunction

	// Whole pipeline moves unless the finished item cannot leave
	assign adv    = !vld_s[LAST] || !o_stat.full;
	assign q_pop  = adv && !q_stat.empty;
	assign o_push = adv && vld_s[LAST];

	// Shift valids along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LAST; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= !q_stat.empty;
			for (int k = 1; k <= LAST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Load the queue head with guard bits
	always_ff @(posedge clk) begin
		if (adv) begin
			rx_s[0] <= CW'(q_head.ax) <<< prot_pkg::GUARD_BITS;
			ry_s[0] <= CW'(q_head.ay) <<< prot_pkg::GUARD_BITS;
			rz_s[0] <= q_head.z;
		end
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		logic signed [CW-1:0] dx_w, dy_w;
		assign dx_w = ry_s[i] >>> i;
		assign dy_w = rx_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!rz_s[i][ZW-1]) begin
					rx_s[i+1] <= rx_s[i] - dx_w;
					ry_s[i+1] <= ry_s[i] + dy_w;
				end else begin
					rx_s[i+1] <= rx_s[i] + dx_w;
					ry_s[i+1] <= ry_s[i] - dy_w;
				end
			end
		end

		if (i < STEPS - 1) begin : g_z
			always_ff @(posedge clk) begin
				if (adv) begin
					if (!rz_s[i][ZW-1]) begin
						rz_s[i+1] <= rz_s[i] - $signed(prot_pkg::ATAN_TAB[i]);
					end else begin
						rz_s[i+1] <= rz_s[i] + $signed(prot_pkg::ATAN_TAB[i]);
					end
				end
			end
		end
	end

	// Gain stage one: partial products of the split value
	always_ff @(posedge clk) begin
		if (adv) begin
			phx_s1 <= PH_W'($signed(rx_s[STEPS][CW-1:SPLIT])) * GAIN_S;
			phy_s1 <= PH_W'($signed(ry_s[STEPS][CW-1:SPLIT])) * GAIN_S;
			plx_s1 <= PL_W'(rx_s[STEPS][SPLIT-1:0]) * PL_W'(prot_pkg::GAIN_Q24);
			ply_s1 <= PL_W'(ry_s[STEPS][SPLIT-1:0]) * PL_W'(prot_pkg::GAIN_Q24);
		end
	end

	// Gain stage two: combine, round half up, saturate
	assign sumx_w = (SW'(phx_s1) <<< SPLIT) + $signed(SW'(plx_s1)) + ROUND_C;
	assign sumy_w = (SW'(phy_s1) <<< SPLIT) + $signed(SW'(ply_s1)) + ROUND_C;

	always_ff @(posedge clk) begin
		if (adv) begin
			resx_s2 <= sat($signed(sumx_w[SW-1:prot_pkg::GAIN_SHIFT]));
			resy_s2 <= sat($signed(sumy_w[SW-1:prot_pkg::GAIN_SHIFT]));
		end
	end

	assign o_data.rx = resx_s2;
	assign o_data.ry = resy_s2;

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAST] && o_stat.full |=> vld_s[LAST] && $stable(resx_s2) && $stable(resy_s2))
		else $error("finished item lost while the result queue was full");

endmodule
`default_nettype wire

@@ design/point_rotate_by_degrees.sv @@
// Top level of the point rotation block: front, middle queue, CORDIC back, result queue.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  input   | push / full          | point_x[23:0], point_y[23:0], angle[15:0]
//  result  | empty / pop          | rotated_x[23:0], rotated_y[23:0]
//
// One item per cycle sustained while the result queue takes items; each CORDIC micro-rotation has its own stage.
// From accept to result visible an item passes 3 front stages, the middle queue,
// ROTATION_STEPS + 3 back stages and the result queue.
// Reset clears valid bits, queue pointers and queue counts only; there is no clearing pass.
// full rises only when the middle queue is full and the front's last stage holds an item;
// the back stalls only while the result queue is full and its last stage holds an item.
`default_nettype none
module point_rotate_by_degrees #(
	parameter int ROTATION_STEPS = prot_pkg::ROTATION_STEPS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic signed [prot_pkg::COORD_W-1:0] point_x,
	input  wire logic signed [prot_pkg::COORD_W-1:0] point_y,
	input  wire logic signed [prot_pkg::ANGLE_W-1:0] angle,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic signed [prot_pkg::COORD_W-1:0]      rotated_x,
	output logic signed [prot_pkg::COORD_W-1:0]      rotated_y
);

	prot_pkg::fifo_stat_t mid_stat, out_stat;
	prot_pkg::mid_entry_t mid_wdata, mid_rdata;
	prot_pkg::out_entry_t out_wdata, out_rdata;
	logic mid_push, mid_pop, out_push;

	// Accept and classify items
	prot_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.point_x (point_x),
		.point_y (point_y),
		.angle   (angle),
		.full    (full),
		.q_stat  (mid_stat),
		.q_push  (mid_push),
		.q_data  (mid_wdata)
	);

	// Decouple front and back
	prot_fifo #(
		.WIDTH ($bits(prot_pkg::mid_entry_t)),
		.DEPTH (prot_pkg::MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.stat   (mid_stat)
	);

	// Rotate, correct gain, saturate
	prot_back #(
		.ROTATION_STEPS (ROTATION_STEPS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_head (mid_rdata),
		.q_stat (mid_stat),
		.q_pop  (mid_pop),
		.o_stat (out_stat),
		.o_push (out_push),
		.o_data (out_wdata)
	);

	// Hold finished items for the consumer
	prot_fifo #(
		.WIDTH ($bits(prot_pkg::out_entry_t)),
		.DEPTH (prot_pkg::OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wdata),
		.pop    (pop && !out_stat.empty),
		.rdata  (out_rdata),
		.stat   (out_stat)
	);

	assign empty     = out_stat.empty;
	assign rotated_x = out_rdata.rx;
	assign rotated_y = out_rdata.ry;

endmodule
`default_nettype wire

@@ sim/point_rotate_by_degrees_tb.sv @@
// Testbench for the point rotation block: CORDIC prediction, scoreboard, queue drivers.

// Holds the predicted rotations in order and checks each result item against them.
class rotation_scoreboard;
	localparam int STEPS_DONE = (prot_pkg::ROTATION_STEPS_DEF > 30) ? 30 :
		prot_pkg::ROTATION_STEPS_DEF;
	localparam longint FULL_TURN = 23040;
	localparam longint QUARTER_TURN = 5760;
	localparam longint EIGHTH_TURN = 2880;
	localparam longint GAIN = 10188014;
	localparam longint SAT_HI = 8388607;
	localparam longint SAT_LO = -8388608;

	prot_pkg::out_entry_t expected_q[$];
	longint atan_turn[30];
	int failures;

	function new();
		failures = 0;
		// atan(2^-i), 2^32 units per turn, truncated
		atan_turn = '{
			64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
			64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
			64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
			64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
			64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
			64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
		};
	endfunction

	// Scale out the CORDIC gain, round half up, saturate to the coordinate range
	function longint scale_and_clip(longint v);
		longint r;
		r = (v * GAIN + (64'sd1 <<< 31)) >>> 32;
		if (r > SAT_HI) r = SAT_HI;
		if (r < SAT_LO) r = SAT_LO;
		return r;
	endfunction

	// Rotate one point: exact quadrant turn, then CORDIC on the residual angle
	function prot_pkg::out_entry_t rotate_point(
		logic signed [prot_pkg::COORD_W-1:0] x,
		logic signed [prot_pkg::COORD_W-1:0] y,
		logic signed [prot_pkg::ANGLE_W-1:0] a
	);
		longint turned, quads, resid, mag, z, vx, vy, dx, dy, nx;
		prot_pkg::out_entry_t res;
		turned = longint'(a) % FULL_TURN;
		if (turned < 0) turned += FULL_TURN;
		quads = (turned + EIGHTH_TURN) / QUARTER_TURN;
		resid = turned - quads * QUARTER_TURN;

		// apply the multiple of 90 degrees by swapping and negating
		case (quads % 4)
			1: begin
				vx = -longint'(y);
				vy = longint'(x);
			end
			2: begin
				vx = -longint'(x);
				vy = -longint'(y);
			end
			3: begin
				vx = longint'(y);
				vy = -longint'(x);
			end
			default: begin
				vx = longint'(x);
				vy = longint'(y);
			end
		endcase

		// residual to binary angle, rounded half away from zero
		mag = (resid < 0) ? -resid : resid;
		z = ((mag <<< 32) + FULL_TURN / 2) / FULL_TURN;
		if (resid < 0) z = -z;

		vx = vx * 256;
		vy = vy * 256;
		for (int i = 0; i < STEPS_DONE; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (z >= 0) begin
				nx = vx - dx;
				vy = vy + dy;
				z -= atan_turn[i];
			end else begin
				nx = vx + dx;
				vy = vy - dy;
				z += atan_turn[i];
			end
			vx = nx;
		end

		res.rx = prot_pkg::COORD_W'(scale_and_clip(vx));
		res.ry = prot_pkg::COORD_W'(scale_and_clip(vy));
		return res;
	endfunction

	function void note_point(
		logic signed [prot_pkg::COORD_W-1:0] x,
		logic signed [prot_pkg::COORD_W-1:0] y,
		logic signed [prot_pkg::ANGLE_W-1:0] a
	);
		expected_q.push_back(rotate_point(x, y, a));
	endfunction

	function void report(string msg);
		failures++;
		if (failures <= 10) $display("%0t: %s", $time, msg);
	endfunction

	// Compare one result item with the oldest prediction, field by field
	function void check_result(
		logic signed [prot_pkg::COORD_W-1:0] rx,
		logic signed [prot_pkg::COORD_W-1:0] ry
	);
		prot_pkg::out_entry_t want;
		if (expected_q.size() == 0) begin
			report($sformatf("item x=%0d y=%0d came out with nothing pending", rx, ry));
			return;
		end
		want = expected_q.pop_front();
		if (rx !== want.rx)
			report($sformatf("rotated_x mismatch: expected %0d, got %0d", want.rx, rx));
		if (ry !== want.ry)
			report($sformatf("rotated_y mismatch: expected %0d, got %0d", want.ry, ry));
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module point_rotate_by_degrees_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = prot_pkg::ROTATION_STEPS_DEF + 20;
	localparam int CW = prot_pkg::COORD_W;
	localparam int AW = prot_pkg::ANGLE_W;
	localparam logic signed [CW-1:0] C_MAX = CW'(prot_pkg::COORD_MAX);
	localparam logic signed [CW-1:0] C_MIN = CW'(prot_pkg::COORD_MIN);
	localparam logic signed [AW-1:0] A_QTR = AW'(prot_pkg::QUARTER_UNITS);
	localparam logic signed [AW-1:0] A_8TH = AW'(prot_pkg::EIGHTH_UNITS);
	localparam logic signed [AW-1:0] A_TURN = AW'(prot_pkg::TURN_UNITS);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic signed [CW-1:0] point_x = '0;
	logic signed [CW-1:0] point_y = '0;
	logic signed [AW-1:0] angle = '0;
	logic full;
	logic empty;
	logic signed [CW-1:0] rotated_x;
	logic signed [CW-1:0] rotated_y;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycle_count = 0;

	rotation_scoreboard sb = new();

	point_rotate_by_degrees DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.point_x   (point_x),
		.point_y   (point_y),
		.angle     (angle),
		.empty     (empty),
		.pop       (pop),
		.rotated_x (rotated_x),
		.rotated_y (rotated_y)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Note accepted points and check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) sb.note_point(point_x, point_y, angle);
			if (pop && !empty) sb.check_result(rotated_x, rotated_y);
		end
	end

	// Drive pop: long hold on request, otherwise random stalls
	always @(negedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			pop <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Stop a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// Offer one point, idling first at random; enter and leave at a falling edge
	task automatic send_point(
		input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y,
		input logic signed [AW-1:0] a
	);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		point_x <= x;
		point_y <= y;
		angle <= a;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	// Change idling away from the falling edge the receiver samples on
	task automatic set_idling(input int send_pct, input int stall_pct);
		push <= 1'b0;
		@(posedge clk);
		send_idle_pct <= send_pct;
		recv_stall_pct <= stall_pct;
		@(negedge clk);
	endtask

	function automatic logic signed [CW-1:0] random_coord();
		case ($urandom_range(9))
			0: return C_MAX;
			1: return C_MIN;
			2: return '0;
			3: return CW'(int'($urandom_range(4095)) - 2048);
			default: return CW'($urandom());
		endcase
	endfunction

	function automatic logic signed [AW-1:0] random_angle();
		case ($urandom_range(9))
			// exact quarter turns
			0: return AW'((int'($urandom_range(8)) - 4) * prot_pkg::QUARTER_UNITS);
			// around the 45 degree split points
			1: return AW'((int'($urandom_range(7)) - 4) * prot_pkg::QUARTER_UNITS
				+ prot_pkg::EIGHTH_UNITS + int'($urandom_range(2)) - 1);
			// any 16-bit angle, wrapping beyond a full turn
			2: return AW'($urandom());
			default: return AW'(int'($urandom_range(2 * prot_pkg::TURN_UNITS))
				- prot_pkg::TURN_UNITS);
		endcase
	endfunction

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero, quarter turns, full turns, split points, wrap, saturation
		send_point('0, '0, '0);
		send_point(C_MAX, C_MIN, '0);
		send_point(24'sd256, 24'sd0, A_QTR);
		send_point(24'sd256, 24'sd0, AW'(2 * prot_pkg::QUARTER_UNITS));
		send_point(24'sd256, 24'sd0, AW'(3 * prot_pkg::QUARTER_UNITS));
		send_point(C_MIN, C_MIN, AW'(2 * prot_pkg::QUARTER_UNITS));
		send_point(24'sd1000, -24'sd2000, A_TURN);
		send_point(24'sd1000, -24'sd2000, -A_TURN);
		send_point(C_MAX, C_MAX, A_8TH);
		send_point(C_MIN, C_MIN, A_8TH);
		send_point(C_MAX, C_MIN, -A_8TH);
		send_point(24'sd12345, 24'sd6789, A_8TH - 16'sd1);
		send_point(24'sd12345, 24'sd6789, -A_8TH - 16'sd1);
		send_point(-24'sd70000, 24'sd33333, 16'sh7FFF);
		send_point(-24'sd70000, 24'sd33333, 16'sh8000);
		send_point(24'sd500000, -24'sd400000, A_TURN + 16'sd1);
		send_point(24'sd500000, -24'sd400000, -A_TURN - 16'sd1);
		send_point(C_MAX, '0, 16'sd1);
		send_point('0, C_MIN, -16'sd1);
		send_point(-24'sd1, -24'sd1, 16'sd1234);
		send_point(C_MAX, C_MAX, AW'(3 * prot_pkg::EIGHTH_UNITS));
		send_point(24'sd1, 24'sd1, AW'(-2 * prot_pkg::QUARTER_UNITS));
		send_point(C_MIN, C_MAX,
			AW'(3 * prot_pkg::QUARTER_UNITS + prot_pkg::EIGHTH_UNITS));

		// random: no idling, sender idle, receiver stalling, both
		repeat (150) send_point(random_coord(), random_coord(), random_angle());
		set_idling(81, 0);
		repeat (150) send_point(random_coord(), random_coord(), random_angle());
		set_idling(0, 81);
		repeat (150) send_point(random_coord(), random_coord(), random_angle());
		set_idling(10, 10);
		repeat (130) send_point(random_coord(), random_coord(), random_angle());

		// hold results back while points keep coming, so the input stalls
		push <= 1'b0;
		@(posedge clk);
		send_idle_pct <= 0;
		recv_stall_pct <= 0;
		hold_asks <= hold_asks + 1;
		@(negedge clk);
		repeat (60) send_point(random_coord(), random_coord(), random_angle());
		push <= 1'b0;

		// drain, then let the pipeline settle
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d items never came out", sb.pending()));
		if (sb.failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

@@ sim.f @@
design/prot_pkg.sv
design/prot_fifo.sv
design/prot_front.sv
design/prot_back.sv
design/point_rotate_by_degrees.sv
sim/point_rotate_by_degrees_tb.sv
